@@ hdl/parl_pkg.sv @@
`default_nettype none
package parl_pkg;

  localparam int TableEntries = 64;
  localparam int WhiteSlots   = 4;

  typedef enum logic [1:0] {
    CMD_OPEN  = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_REQ   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_ADMIT  = 2'd0,
    ST_BYPASS = 2'd1,
    ST_OVER   = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_MAX_CONN = 3'd0,
    REG_MAX_RATE = 3'd1,
    REG_IDLE     = 3'd2,
    REG_WCOUNT   = 3'd3,
    REG_WADDR0   = 3'd4,
    REG_WADDR1   = 3'd5,
    REG_WADDR2   = 3'd6,
    REG_WADDR3   = 3'd7
  } reg_idx_t;

  // Broadcast from the controller to every cell for one command.
  typedef struct packed {
    logic        lookup;   // latch match for ip
    logic        sweep;    // free idle unused entries
    logic        alloc;    // take entry if first free and no hit anywhere
    logic        apply;    // perform command on the hit entry
    cmd_t        cmd;
    logic [31:0] ip;
    logic [31:0] now;
    logic [15:0] limit;
    logic [15:0] idle;
  } cell_ctl_t;

  // Chained along the row: lowest-index priority for hit and free.
  typedef struct packed {
    logic        hit_seen;
    logic        free_seen;
    logic [15:0] conns;
    logic        over;
  } cell_chain_t;

endpackage
`default_nettype wire

@@ hdl/parl_if.sv @@
`default_nettype none
interface parl_cmd_if;
  import parl_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] ip_addr;
  logic [31:0] now_sec;
  modport source (output valid, command, ip_addr, now_sec, input ready);
  modport sink   (input valid, command, ip_addr, now_sec, output ready);
endinterface

interface parl_res_if;
  logic        valid;
  logic        ready;
  logic        allowed;
  logic [1:0]  status;
  logic [15:0] conn_count;
  modport source (output valid, allowed, status, conn_count, input ready);
  modport sink   (input valid, allowed, status, conn_count, output ready);
endinterface
`default_nettype wire

@@ hdl/per_address_conn_and_rate_limiter_unit.sv @@
`default_nettype none
// Channel  | Dir | Payload                               | Handshake
// cmd      | in  | command, ip_addr, now_sec             | valid/ready
// res      | out | allowed, status, conn_count           | valid/ready
// apb      | in  | 8 regs at 4*i, 32-bit data            | psel/penable, pready=1
//
// Every command passes the sweep, lookup, allocate and update stages after
// acceptance; close, read and bypassed commands leave sweep and allocate idle,
// and only close among them updates its entry. A new request is taken only
// once the previous command has returned to idle.
// Reset clears all entry valid bits and the sweep clock at once; no pass.
// A finished result waits in the output register; the next command is
// accepted as soon as the result register is free or being drained.
module per_address_conn_and_rate_limiter_unit
  import parl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  parl_cmd_if.sink         cmd,
  parl_res_if.source       res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [2:0] {S_IDLE, S_SWEEP, S_LOOK, S_ALLOC, S_APPLY, S_DONE} state_t;

  // Configuration registers.
  logic [15:0] max_conn, max_rate, idle_timeout;
  logic [2:0]  white_count;
  logic [31:0] white_addr [WhiteSlots];
  reg_idx_t    widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_conn     <= '0;
      max_rate     <= '0;
      idle_timeout <= '0;
      white_count  <= '0;
      for (int i = 0; i < WhiteSlots; i++) white_addr[i] <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_MAX_CONN: max_conn     <= pwdata[15:0];
        REG_MAX_RATE: max_rate     <= pwdata[15:0];
        REG_IDLE:     idle_timeout <= pwdata[15:0];
        REG_WCOUNT:   white_count  <= pwdata[2:0];
        REG_WADDR0:   white_addr[0] <= pwdata;
        REG_WADDR1:   white_addr[1] <= pwdata;
        REG_WADDR2:   white_addr[2] <= pwdata;
        REG_WADDR3:   white_addr[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_MAX_CONN: prdata = {16'd0, max_conn};
      REG_MAX_RATE: prdata = {16'd0, max_rate};
      REG_IDLE:     prdata = {16'd0, idle_timeout};
      REG_WCOUNT:   prdata = {29'd0, white_count};
      REG_WADDR0:   prdata = white_addr[0];
      REG_WADDR1:   prdata = white_addr[1];
      REG_WADDR2:   prdata = white_addr[2];
      REG_WADDR3:   prdata = white_addr[3];
      default:      prdata = '0;
    endcase
  end

  // Held request.
  state_t      state;
  cmd_t        r_cmd;
  logic [31:0] r_ip, r_now, last_sweep;
  logic [15:0] r_limit;
  logic        res_valid, res_allowed;
  logic [1:0]  res_status;
  logic [15:0] res_count;
  logic        accept;
  logic        white_hit;
  logic        limited;
  logic        sweep_due;
  cell_ctl_t   ctl;
  cell_chain_t tail;

  // Whitelist compare on the held address; stable from the sweep stage on.
  always_comb begin
    white_hit = 1'b0;
    for (int i = 0; i < WhiteSlots; i++)
      if ({29'd0, white_count} > i && white_addr[i] == r_ip) white_hit = 1'b1;
  end

  assign limited   = !white_hit && r_limit != 16'd0 &&
                     (r_cmd == CMD_OPEN || r_cmd == CMD_REQ);
  assign sweep_due = idle_timeout != 16'd0 &&
                     (last_sweep == 32'd0 || (r_now - last_sweep) >= {16'd0, idle_timeout});

  assign cmd.ready = (state == S_IDLE) && (!res_valid || res.ready);
  assign accept    = cmd.valid && cmd.ready;

  always_comb begin
    ctl        = '0;
    ctl.cmd    = r_cmd;
    ctl.ip     = r_ip;
    ctl.now    = r_now;
    ctl.limit  = r_limit;
    ctl.idle   = idle_timeout;
    ctl.sweep  = (state == S_SWEEP) && limited && sweep_due;
    ctl.lookup = (state == S_LOOK);
    ctl.alloc  = (state == S_ALLOC) && limited;
    ctl.apply  = (state == S_APPLY) && !(r_cmd != CMD_CLOSE && !limited);
  end

  assign res.valid      = res_valid;
  assign res.allowed    = res_allowed;
  assign res.status     = res_status;
  assign res.conn_count = res_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      last_sweep <= '0;
    end else begin
      if (res_valid && res.ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept) begin
          r_cmd   <= cmd_t'(cmd.command);
          r_ip    <= cmd.ip_addr;
          r_now   <= cmd.now_sec;
          r_limit <= (cmd_t'(cmd.command) == CMD_OPEN) ? max_conn : max_rate;
          state   <= S_SWEEP;
        end
        S_SWEEP: begin
          // Sweep before the lookup.
          if (ctl.sweep) last_sweep <= r_now;
          state <= S_LOOK;
        end
        S_LOOK:  state <= S_ALLOC;
        S_ALLOC: state <= S_APPLY;
        S_APPLY: begin
          // The chain reports the entry before the update lands.
          res_valid <= 1'b1;
          if (r_cmd == CMD_CLOSE || r_cmd == CMD_READ) begin
            res_allowed <= 1'b0;
            res_status  <= ST_ADMIT;
            res_count   <= !tail.hit_seen ? 16'd0 :
                           (r_cmd == CMD_CLOSE && tail.conns != 16'd0) ?
                           tail.conns - 16'd1 : tail.conns;
          end else if (!limited) begin
            res_allowed <= 1'b1;
            res_status  <= ST_BYPASS;
            res_count   <= tail.hit_seen ? tail.conns : 16'd0;
          end else if (!tail.hit_seen) begin
            res_allowed <= 1'b0;
            res_status  <= ST_FULL;
            res_count   <= 16'd0;
          end else if (tail.over) begin
            res_allowed <= 1'b0;
            res_status  <= ST_OVER;
            res_count   <= tail.conns;
          end else begin
            res_allowed <= 1'b1;
            res_status  <= ST_ADMIT;
            res_count   <= (r_cmd == CMD_OPEN) ? tail.conns + 16'd1 : tail.conns;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  parl_row u_row (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .tail(tail)
  );

  // Accept only when idle and the result register can be freed.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |-> state == S_IDLE) else $error("accept outside idle");
  // Each accepted request shows its result after the sweep, lookup, allocate and apply states.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5 res_valid) else $error("missing result");
  // Table full is only reported for limited open or request, and never as allowed.
  a_full_limited: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status == ST_FULL) |-> !res_allowed) else $error("full but allowed");

endmodule
`default_nettype wire

@@ hdl/parl_cell.sv @@
`default_nettype none
module parl_cell
  import parl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cell_ctl_t   ctl,
  input  wire cell_chain_t chain_in,
  input  wire logic        any_hit,
  output cell_chain_t      chain_out
);

  logic        valid;
  logic [31:0] addr;
  logic [15:0] conns;
  logic [31:0] window;
  logic [15:0] wcount;
  logic [31:0] last_seen;
  logic        hit;

  logic        mine;
  logic        take;
  logic [15:0] wc_eff;
  logic [31:0] idle_age;

  assign mine     = hit && !chain_in.hit_seen;
  assign take     = ctl.alloc && !any_hit && !valid && !chain_in.free_seen;
  assign wc_eff   = (window != ctl.now) ? 16'd0 : wcount;
  assign idle_age = ctl.now - last_seen;

  always_comb begin
    chain_out = chain_in;
    if (mine) begin
      chain_out.hit_seen = 1'b1;
      chain_out.conns    = conns;
      chain_out.over     = (ctl.cmd == CMD_OPEN) ? (conns >= ctl.limit)
                                                 : (wc_eff >= ctl.limit);
    end
    if (!valid) chain_out.free_seen = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      if (ctl.lookup) hit <= valid && (addr == ctl.ip);
      if (ctl.sweep && valid && conns == 16'd0 && idle_age > {16'd0, ctl.idle}) begin
        valid <= 1'b0;
        hit   <= 1'b0;
      end
      if (take) begin
        valid <= 1'b1;
        hit   <= 1'b1;
      end
      if (ctl.apply && mine) begin
        unique case (ctl.cmd)
          CMD_CLOSE: if (conns != 16'd0) conns <= conns - 16'd1;
          CMD_OPEN: if (conns < ctl.limit) begin
            conns     <= conns + 16'd1;
            last_seen <= ctl.now;
          end
          CMD_REQ: begin
            window <= ctl.now;
            if (wc_eff < ctl.limit) begin
              wcount    <= wc_eff + 16'd1;
              last_seen <= ctl.now;
            end else begin
              wcount <= wc_eff;
            end
          end
          default: ;
        endcase
      end
    end
    if (take) begin
      addr      <= ctl.ip;
      conns     <= 16'd0;
      window    <= ctl.now;
      wcount    <= 16'd0;
      last_seen <= ctl.now;
    end
  end

endmodule
`default_nettype wire

@@ hdl/parl_row.sv @@
`default_nettype none
module parl_row
  import parl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_ctl_t ctl,
  output cell_chain_t    tail
);

  cell_chain_t chain [TableEntries+1];
  logic        any_hit;

  assign chain[0] = '0;
  assign tail     = chain[TableEntries];
  assign any_hit  = tail.hit_seen;

  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    parl_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .chain_in (chain[g]),
      .any_hit  (any_hit),
      .chain_out(chain[g+1])
    );
  end

endmodule
`default_nettype wire
